FILE: rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, codes and reset values of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Bits per transferred byte
  localparam int unsigned BYTE_BITS = 8;
  localparam logic [3:0]  BYTE_BITS_CNT = 4'(BYTE_BITS);

  // Register reset values
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

  // Register indexes (paddr[2])
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  // Command opcodes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_WAIT  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_A    = 4'd1;
  localparam logic [3:0] PH_START_B    = 4'd2;
  localparam logic [3:0] PH_STOP_A     = 4'd3;
  localparam logic [3:0] PH_STOP_B     = 4'd4;
  localparam logic [3:0] PH_WR_LOW     = 4'd5;
  localparam logic [3:0] PH_WR_HIGH    = 4'd6;
  localparam logic [3:0] PH_ACKW_LOW   = 4'd7;
  localparam logic [3:0] PH_ACKW_POLL  = 4'd8;
  localparam logic [3:0] PH_RD_LOW     = 4'd9;
  localparam logic [3:0] PH_RD_HIGH    = 4'd10;
  localparam logic [3:0] PH_RDACK_LOW  = 4'd11;
  localparam logic [3:0] PH_RDACK_HIGH = 4'd12;

  // One input word
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // One result word
  typedef struct packed {
    logic       scl_out;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } result_t;

  // Bus timing settings
  typedef struct packed {
    logic [15:0] half_period;
    logic [7:0]  ack_timeout;
  } timing_t;

endpackage

FILE: rtl/i2cms_core.sv
// ----------------------------------------------------------------------------
// i2cms_core
// Sequencer state and one-tick update: takes one registered input word per
// step and presents the result word of that step.
// ----------------------------------------------------------------------------
module i2cms_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  i2cms_pkg::item_t   item_i,
  input  i2cms_pkg::timing_t timing_i,
  output i2cms_pkg::result_t result_o
);

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  bit_index_q, bit_index_d;
  logic [7:0]  shift_byte_q, shift_byte_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic [7:0]  poll_count_q, poll_count_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        ack_choice_q, ack_choice_d;
  logic        error_q, error_d;
  logic [7:0]  rx_byte_q, rx_byte_d;
  logic        done;
  logic [15:0] half_ticks;

  // Treat a zero half period as one tick
  assign half_ticks = (timing_i.half_period == 16'd0) ? 16'd1 : timing_i.half_period;

  // Compute the next state for one tick
  always_comb begin
    logic [3:0] bit_next;
    phase_d      = phase_q;
    bit_index_d  = bit_index_q;
    shift_byte_d = shift_byte_q;
    tick_count_d = tick_count_q;
    poll_count_d = poll_count_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    ack_choice_d = ack_choice_q;
    error_d      = error_q;
    rx_byte_d    = rx_byte_q;
    done         = 1'b0;
    bit_next     = bit_index_q + 4'd1;

    if (phase_q == i2cms_pkg::PH_IDLE) begin
      if (item_i.cmd_valid &&
          (item_i.opcode inside {[i2cms_pkg::OP_START:i2cms_pkg::OP_READ]})) begin
        tick_count_d = 16'd1;
        case (item_i.opcode)
          i2cms_pkg::OP_START: begin
            phase_d = i2cms_pkg::PH_START_A;
            scl_d   = 1'b1;
            sda_d   = 1'b1;
          end
          i2cms_pkg::OP_STOP: begin
            phase_d = i2cms_pkg::PH_STOP_A;
            scl_d   = 1'b0;
            sda_d   = 1'b0;
          end
          i2cms_pkg::OP_WRITE: begin
            bit_index_d  = 4'd0;
            phase_d      = i2cms_pkg::PH_WR_LOW;
            scl_d        = 1'b0;
            sda_d        = item_i.write_data[i2cms_pkg::BYTE_BITS-1];
            shift_byte_d = {item_i.write_data[i2cms_pkg::BYTE_BITS-2:0], 1'b0};
          end
          i2cms_pkg::OP_WAIT: begin
            error_d      = 1'b0;
            poll_count_d = 8'd0;
            phase_d      = i2cms_pkg::PH_ACKW_LOW;
            scl_d        = 1'b0;
            sda_d        = 1'b1;
          end
          i2cms_pkg::OP_READ: begin
            ack_choice_d = item_i.send_ack;
            bit_index_d  = 4'd0;
            rx_byte_d    = 8'd0;
            phase_d      = i2cms_pkg::PH_RD_LOW;
            scl_d        = 1'b0;
            sda_d        = 1'b1;
          end
          default: begin
            tick_count_d = tick_count_q;
          end
        endcase
      end
    end else if (phase_q == i2cms_pkg::PH_ACKW_POLL) begin
      // Poll SDA every tick until low or timeout
      if (!item_i.sda_in) begin
        error_d      = 1'b0;
        phase_d      = i2cms_pkg::PH_IDLE;
        tick_count_d = 16'd0;
        scl_d        = 1'b0;
        done         = 1'b1;
      end else if (poll_count_q >= timing_i.ack_timeout) begin
        error_d      = 1'b1;
        phase_d      = i2cms_pkg::PH_STOP_A;
        scl_d        = 1'b0;
        sda_d        = 1'b0;
        tick_count_d = 16'd1;
      end else begin
        poll_count_d = poll_count_q + 8'd1;
      end
    end else if (tick_count_q < half_ticks) begin
      tick_count_d = tick_count_q + 16'd1;
    end else begin
      // Segment over: advance to the next segment
      tick_count_d = 16'd1;
      case (phase_q)
        i2cms_pkg::PH_START_A: begin
          phase_d = i2cms_pkg::PH_START_B;
          scl_d   = 1'b1;
          sda_d   = 1'b0;
        end
        i2cms_pkg::PH_START_B: begin
          phase_d      = i2cms_pkg::PH_IDLE;
          tick_count_d = 16'd0;
          scl_d        = 1'b0;
          done         = 1'b1;
        end
        i2cms_pkg::PH_STOP_A: begin
          phase_d = i2cms_pkg::PH_STOP_B;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
        end
        i2cms_pkg::PH_STOP_B: begin
          phase_d      = i2cms_pkg::PH_IDLE;
          tick_count_d = 16'd0;
          done         = 1'b1;
        end
        i2cms_pkg::PH_WR_LOW: begin
          phase_d = i2cms_pkg::PH_WR_HIGH;
          scl_d   = 1'b1;
        end
        i2cms_pkg::PH_WR_HIGH: begin
          bit_index_d = bit_next;
          if (bit_next >= i2cms_pkg::BYTE_BITS_CNT) begin
            phase_d      = i2cms_pkg::PH_IDLE;
            tick_count_d = 16'd0;
            scl_d        = 1'b0;
            done         = 1'b1;
          end else begin
            phase_d      = i2cms_pkg::PH_WR_LOW;
            scl_d        = 1'b0;
            sda_d        = shift_byte_q[i2cms_pkg::BYTE_BITS-1];
            shift_byte_d = {shift_byte_q[i2cms_pkg::BYTE_BITS-2:0], 1'b0};
          end
        end
        i2cms_pkg::PH_ACKW_LOW: begin
          phase_d      = i2cms_pkg::PH_ACKW_POLL;
          scl_d        = 1'b1;
          sda_d        = 1'b1;
          poll_count_d = 8'd0;
        end
        i2cms_pkg::PH_RD_LOW: begin
          phase_d   = i2cms_pkg::PH_RD_HIGH;
          scl_d     = 1'b1;
          sda_d     = 1'b1;
          rx_byte_d = {rx_byte_q[6:0], item_i.sda_in};
        end
        i2cms_pkg::PH_RD_HIGH: begin
          bit_index_d = bit_next;
          scl_d       = 1'b0;
          if (bit_next >= i2cms_pkg::BYTE_BITS_CNT) begin
            phase_d = i2cms_pkg::PH_RDACK_LOW;
            sda_d   = !ack_choice_q;
          end else begin
            phase_d = i2cms_pkg::PH_RD_LOW;
            sda_d   = 1'b1;
          end
        end
        i2cms_pkg::PH_RDACK_LOW: begin
          phase_d = i2cms_pkg::PH_RDACK_HIGH;
          scl_d   = 1'b1;
        end
        i2cms_pkg::PH_RDACK_HIGH: begin
          phase_d      = i2cms_pkg::PH_IDLE;
          tick_count_d = 16'd0;
          scl_d        = 1'b0;
          done         = 1'b1;
        end
        default: begin
          phase_d      = i2cms_pkg::PH_IDLE;
          tick_count_d = 16'd0;
        end
      endcase
    end
  end

  // Advance the state on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= i2cms_pkg::PH_IDLE;
      bit_index_q  <= 4'd0;
      shift_byte_q <= 8'd0;
      tick_count_q <= 16'd0;
      poll_count_q <= 8'd0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      ack_choice_q <= 1'b0;
      error_q      <= 1'b0;
      rx_byte_q    <= 8'd0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      bit_index_q  <= bit_index_d;
      shift_byte_q <= shift_byte_d;
      tick_count_q <= tick_count_d;
      poll_count_q <= poll_count_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      ack_choice_q <= ack_choice_d;
      error_q      <= error_d;
      rx_byte_q    <= rx_byte_d;
    end
  end

  // Present the post-update levels
  assign result_o.scl_out       = scl_d;
  assign result_o.sda_drive_low = !sda_d;
  assign result_o.busy_res      = (phase_d != i2cms_pkg::PH_IDLE);
  assign result_o.done_res      = done;
  assign result_o.read_data     = rx_byte_d;
  assign result_o.ack_error     = error_d;

endmodule

FILE: rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C bus master stepped by one input word per tick, with APB timing regs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per bus tick:
//   a command offer (cmd_valid_i, opcode_i, write_data_i, send_ack_i) and the
//   sampled SDA level (sda_in_i). Every word yields exactly one result word
//   on the output channel (out_valid_o / out_ready_i): SCL level, SDA pull,
//   busy, done pulse, received byte and ack error.
//   A word accepted into the input register has its result loaded into the
//   output register when the sequencer steps on it; that step waits while
//   a stalled result is held, and the load raises out_valid_o.
//   Throughput: one word per cycle unless the output stalls; the single-tick
//   update between the input and output registers sets that rate.
//   Stall: while out_ready_i is low the result holds; one more word is taken
//   into the input register, then in_ready_o drops until the result drains.
//   Reset: both registers empty, sequencer idle with SCL high and SDA
//   released, half period 100 ticks, ack timeout 250 polls.
//   Registers: half_period_ticks at 0x0, ack_timeout_polls at 0x4.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_valid_i,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  write_data_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_drive_low_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  read_data_o,
  output logic        ack_error_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cms_pkg::item_t   item_q;
  i2cms_pkg::result_t result_d;
  i2cms_pkg::result_t result_q;
  i2cms_pkg::timing_t timing;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               step;
  logic               cfg_write;
  logic [15:0]        half_period_q;
  logic [7:0]         ack_timeout_q;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= i2cms_pkg::HALF_PERIOD_RESET;
      ack_timeout_q <= i2cms_pkg::ACK_TIMEOUT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == i2cms_pkg::REG_HALF_PERIOD) begin
        half_period_q <= pwdata[15:0];
      end else begin
        ack_timeout_q <= pwdata[7:0];
      end
    end
  end

  assign prdata = (paddr[2] == i2cms_pkg::REG_ACK_TIMEOUT) ? {24'd0, ack_timeout_q}
                                                           : {16'd0, half_period_q};

  assign timing.half_period = half_period_q;
  assign timing.ack_timeout = ack_timeout_q;

  // Step when the input register holds a word and the output can take it
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.cmd_valid  <= cmd_valid_i;
      item_q.opcode     <= opcode_i;
      item_q.write_data <= write_data_i;
      item_q.send_ack   <= send_ack_i;
      item_q.sda_in     <= sda_in_i;
    end
  end

  // Sequencer
  i2cms_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .timing_i (timing),
    .result_o (result_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scl_out_o       = result_q.scl_out;
  assign sda_drive_low_o = result_q.sda_drive_low;
  assign busy_res_o      = result_q.busy_res;
  assign done_res_o      = result_q.done_res;
  assign read_data_o     = result_q.read_data;
  assign ack_error_o     = result_q.ack_error;

  // A completing command leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done raised while still busy");

  // A held word is not dropped while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |=> in_valid_q)
    else $error("input word lost during output stall");

  // A stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !step)
    else $error("step taken while result is stalled");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C master bit sequencer. Bus-tick words
// (command offer plus SDA sample) go in through the valid/ready input. A cycle
// model of the sequencer predicts the result word of every tick, and the
// output stream is checked in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_valid_i;
  logic [2:0]  opcode_i;
  logic [7:0]  write_data_i;
  logic        send_ack_i;
  logic        sda_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        scl_out_o;
  logic        sda_drive_low_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  read_data_o;
  logic        ack_error_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  i2c_master_bit_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_valid_i    (cmd_valid_i),
    .opcode_i       (opcode_i),
    .write_data_i   (write_data_i),
    .send_ack_i     (send_ack_i),
    .sda_in_i       (sda_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .scl_out_o      (scl_out_o),
    .sda_drive_low_o(sda_drive_low_o),
    .busy_res_o     (busy_res_o),
    .done_res_o     (done_res_o),
    .read_data_o    (read_data_o),
    .ack_error_o    (ack_error_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Bus timing settings as the sequencer sees them
  logic [15:0] half_period;
  logic [7:0]  ack_timeout;

  // Sequencer state
  logic [3:0]  seq_phase;
  logic [3:0]  bit_cnt;
  logic [7:0]  tx_byte;
  logic [15:0] seg_ticks;
  logic [7:0]  poll_cnt;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        ack_sel;
  logic        ack_err;
  logic [7:0]  rx_byte;

  // Result words still owed by the sequencer, oldest first
  i2cms_pkg::result_t bus_levels_q[$];
  i2cms_pkg::result_t got_word;
  i2cms_pkg::result_t want_word;

  // Slave behavior during wait-ack: polls answered high before the ack
  int          ack_delay;
  int          polls_sent;

  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          hold_cycles;
  int          errors;
  int unsigned cycle_cnt;

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------
  function automatic void enter_segment(logic [3:0] ph, logic scl, logic sda);
    seq_phase = ph;
    scl_lvl   = scl;
    sda_lvl   = sda;
    seg_ticks = 16'd1;
  endfunction

  // Put the next data bit on SDA with SCL low, MSB first
  function automatic void load_tx_bit();
    enter_segment(i2cms_pkg::PH_WR_LOW, 1'b0, tx_byte[7]);
    tx_byte = tx_byte << 1;
  endfunction

  function automatic logic end_command();
    seq_phase = i2cms_pkg::PH_IDLE;
    seg_ticks = '0;
    scl_lvl   = 1'b0;
    return 1'b1;
  endfunction

  // Close the running segment and open the next one; returns the done pulse
  function automatic logic next_segment(logic sda_smp);
    logic fin;
    fin = 1'b0;
    case (seq_phase)
      i2cms_pkg::PH_START_A: enter_segment(i2cms_pkg::PH_START_B, 1'b1, 1'b0);
      i2cms_pkg::PH_START_B: fin = end_command();
      i2cms_pkg::PH_STOP_A:  enter_segment(i2cms_pkg::PH_STOP_B, 1'b1, 1'b1);
      i2cms_pkg::PH_STOP_B: begin
        seq_phase = i2cms_pkg::PH_IDLE;
        seg_ticks = '0;
        fin       = 1'b1;
      end
      i2cms_pkg::PH_WR_LOW:  enter_segment(i2cms_pkg::PH_WR_HIGH, 1'b1, sda_lvl);
      i2cms_pkg::PH_WR_HIGH: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= i2cms_pkg::BYTE_BITS_CNT) fin = end_command();
        else load_tx_bit();
      end
      i2cms_pkg::PH_ACKW_LOW: begin
        enter_segment(i2cms_pkg::PH_ACKW_POLL, 1'b1, 1'b1);
        poll_cnt = '0;
      end
      i2cms_pkg::PH_RD_LOW: begin
        // sample SDA on the first tick with SCL high
        enter_segment(i2cms_pkg::PH_RD_HIGH, 1'b1, 1'b1);
        rx_byte = {rx_byte[6:0], sda_smp};
      end
      i2cms_pkg::PH_RD_HIGH: begin
        bit_cnt = bit_cnt + 4'd1;
        if (bit_cnt >= i2cms_pkg::BYTE_BITS_CNT) begin
          enter_segment(i2cms_pkg::PH_RDACK_LOW, 1'b0, !ack_sel);
        end else begin
          enter_segment(i2cms_pkg::PH_RD_LOW, 1'b0, 1'b1);
        end
      end
      i2cms_pkg::PH_RDACK_LOW:  enter_segment(i2cms_pkg::PH_RDACK_HIGH, 1'b1, sda_lvl);
      i2cms_pkg::PH_RDACK_HIGH: fin = end_command();
      default: begin
        seq_phase = i2cms_pkg::PH_IDLE;
        seg_ticks = '0;
      end
    endcase
    return fin;
  endfunction

  // Advance the model by one bus tick and return the levels it shows
  function automatic i2cms_pkg::result_t predict_bus_tick(i2cms_pkg::item_t w);
    logic [15:0]        h;
    logic               fin;
    i2cms_pkg::result_t r;
    h   = (half_period == '0) ? 16'd1 : half_period;
    fin = 1'b0;
    if (seq_phase == i2cms_pkg::PH_IDLE) begin
      if (w.cmd_valid) begin
        case (w.opcode)
          i2cms_pkg::OP_START: enter_segment(i2cms_pkg::PH_START_A, 1'b1, 1'b1);
          i2cms_pkg::OP_STOP:  enter_segment(i2cms_pkg::PH_STOP_A, 1'b0, 1'b0);
          i2cms_pkg::OP_WRITE: begin
            tx_byte = w.write_data;
            bit_cnt = '0;
            load_tx_bit();
          end
          i2cms_pkg::OP_WAIT: begin
            ack_err  = 1'b0;
            poll_cnt = '0;
            enter_segment(i2cms_pkg::PH_ACKW_LOW, 1'b0, 1'b1);
          end
          i2cms_pkg::OP_READ: begin
            ack_sel = w.send_ack;
            bit_cnt = '0;
            rx_byte = '0;
            enter_segment(i2cms_pkg::PH_RD_LOW, 1'b0, 1'b1);
          end
          default: ;
        endcase
      end
    end else if (seq_phase == i2cms_pkg::PH_ACKW_POLL) begin
      // poll SDA every tick; too many high polls end in a stop with error
      if (!w.sda_in) begin
        ack_err = 1'b0;
        fin     = end_command();
      end else if (poll_cnt >= ack_timeout) begin
        ack_err = 1'b1;
        enter_segment(i2cms_pkg::PH_STOP_A, 1'b0, 1'b0);
      end else begin
        poll_cnt = poll_cnt + 8'd1;
      end
    end else if (seg_ticks < h) begin
      seg_ticks = seg_ticks + 16'd1;
    end else begin
      fin = next_segment(w.sda_in);
    end
    r.scl_out       = scl_lvl;
    r.sda_drive_low = !sda_lvl;
    r.busy_res      = (seq_phase != i2cms_pkg::PH_IDLE);
    r.done_res      = fin;
    r.read_data     = rx_byte;
    r.ack_error     = ack_err;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Pick the next bus word: mostly commands when idle, mostly quiet when busy
  function automatic i2cms_pkg::item_t next_bus_word();
    i2cms_pkg::item_t w;
    int               pick;
    w.cmd_valid  = 1'b0;
    w.opcode     = 3'($urandom_range(7));
    w.write_data = 8'($urandom);
    w.send_ack   = 1'($urandom);
    w.sda_in     = 1'($urandom);
    if (seq_phase == i2cms_pkg::PH_IDLE) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        w.cmd_valid = 1'b1;
        w.opcode    = 3'($urandom_range(i2cms_pkg::OP_READ, i2cms_pkg::OP_START));
      end else if (pick < 85) begin
        w.cmd_valid = 1'b1;
        w.opcode    = 3'($urandom_range(7, i2cms_pkg::OP_READ + 3'd1));
      end
      if (w.cmd_valid && w.opcode == i2cms_pkg::OP_WAIT) begin
        ack_delay  = $urandom_range(int'(ack_timeout) + 2);
        polls_sent = 0;
      end
    end else if (seq_phase == i2cms_pkg::PH_ACKW_POLL) begin
      w.sda_in   = (polls_sent < ack_delay);
      polls_sent = polls_sent + 1;
    end else begin
      // stray command offers while busy must be ignored
      w.cmd_valid = ($urandom_range(99) < 10);
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then record what it should produce
  task automatic send_word(input i2cms_pkg::item_t w);
    @(negedge clk_i);
    // idle the sender cycle by cycle at the chosen rate
    while ((snd_idle_pct != 0) && ($urandom_range(99) < snd_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_valid_i  <= w.cmd_valid;
    opcode_i     <= w.opcode;
    write_data_i <= w.write_data;
    send_ack_i   <= w.send_ack;
    sda_in_i     <= w.sda_in;
    do @(posedge clk_i); while (!in_ready_o);
    bus_levels_q.push_back(predict_bus_tick(w));
  endtask

  task automatic run_to_idle();
    while (seq_phase != i2cms_pkg::PH_IDLE) send_word(next_bus_word());
  endtask

  // Issue one command and clock the bus until it completes
  task automatic do_command(input logic [2:0] op, input logic [7:0] data,
                            input logic sack, input int delay);
    i2cms_pkg::item_t w;
    w.cmd_valid  = 1'b1;
    w.opcode     = op;
    w.write_data = data;
    w.send_ack   = sack;
    w.sda_in     = 1'($urandom);
    ack_delay    = delay;
    polls_sent   = 0;
    send_word(w);
    run_to_idle();
  endtask

  // Drop valid and wait until every owed result word has drained
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == i2cms_pkg::REG_HALF_PERIOD) half_period = value[15:0];
    else ack_timeout = value[7:0];
  endtask

  task automatic set_timing(input logic [15:0] hp, input logic [7:0] tmo);
    settle();
    reg_write(i2cms_pkg::REG_HALF_PERIOD, 32'(hp));
    reg_write(i2cms_pkg::REG_ACK_TIMEOUT, 32'(tmo));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Undefined opcodes and quiet ticks leave the bus released after reset
  task automatic test_reset_levels();
    i2cms_pkg::item_t w;
    w = next_bus_word();
    w.cmd_valid = 1'b0;
    send_word(w);
    for (int op = i2cms_pkg::OP_READ + 1; op <= 7; op++) begin
      w = next_bus_word();
      w.cmd_valid = 1'b1;
      w.opcode    = 3'(op);
      send_word(w);
    end
  endtask

  task automatic test_directed_commands();
    set_timing(16'd1, 8'd0);
    do_command(i2cms_pkg::OP_START, 8'h00, 1'b0, 0);
    do_command(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0, 0);
    do_command(i2cms_pkg::OP_WRITE, 8'h00, 1'b1, 0);
    // ack on the first poll, then zero timeout fails on the first high poll
    do_command(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, 0);
    do_command(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, 1);
    // reads leave ack_error as the failed wait set it
    do_command(i2cms_pkg::OP_READ, 8'h00, 1'b1, 0);
    do_command(i2cms_pkg::OP_READ, 8'hFF, 1'b0, 0);
    do_command(i2cms_pkg::OP_STOP, 8'h00, 1'b0, 0);
    // zero half period runs like one tick; ack exactly at and past the limit
    set_timing(16'd0, 8'd3);
    do_command(i2cms_pkg::OP_WRITE, 8'hA5, 1'b0, 0);
    do_command(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, 3);
    do_command(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, 4);
  endtask

  task automatic test_max_timing();
    i2cms_pkg::item_t w;
    set_timing(16'hFFFF, 8'hFF);
    w = next_bus_word();
    w.cmd_valid = 1'b1;
    w.opcode    = i2cms_pkg::OP_START;
    send_word(w);
    repeat (20) send_word(next_bus_word());
    // cut the long segment short and finish the start
    set_timing(16'd1, 8'hFF);
    run_to_idle();
    do_command(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, 255);
    do_command(i2cms_pkg::OP_WAIT, 8'h00, 1'b0, 300);
  endtask

  task automatic test_random_traffic(input int snd, input int rcv, input int words);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    for (int i = 0; i < words; i++) begin
      if (i % 125 == 0) set_timing(16'($urandom_range(4)), 8'($urandom_range(8)));
      send_word(next_bus_word());
    end
  endtask

  // Hold the output off long enough for the input side to stall
  task automatic test_backpressure();
    set_timing(16'd2, 8'd4);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_cycles  = 60;
    repeat (40) send_word(next_bus_word());
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and sequencing
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_valid_i  = 1'b0;
    opcode_i     = i2cms_pkg::OP_START;
    write_data_i = '0;
    send_ack_i   = 1'b0;
    sda_in_i     = 1'b1;
    out_ready_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    half_period  = i2cms_pkg::HALF_PERIOD_RESET;
    ack_timeout  = i2cms_pkg::ACK_TIMEOUT_RESET;
    seq_phase    = i2cms_pkg::PH_IDLE;
    bit_cnt      = '0;
    tx_byte      = '0;
    seg_ticks    = '0;
    poll_cnt     = '0;
    scl_lvl      = 1'b1;
    sda_lvl      = 1'b1;
    ack_sel      = 1'b0;
    ack_err      = 1'b0;
    rx_byte      = '0;
    ack_delay    = 0;
    polls_sent   = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_cycles  = 0;
    errors       = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_levels();
    test_directed_commands();
    test_max_timing();
    test_random_traffic(29, 53, 400);
    test_random_traffic(53, 29, 400);
    test_random_traffic(0, 0, 400);
    test_backpressure();

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Drive output ready: long hold first, else random idling
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready_i <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Check each result word against the oldest owed word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_word.scl_out       = scl_out_o;
      got_word.sda_drive_low = sda_drive_low_o;
      got_word.busy_res      = busy_res_o;
      got_word.done_res      = done_res_o;
      got_word.read_data     = read_data_o;
      got_word.ack_error     = ack_error_o;
      if (bus_levels_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= MAX_REPORTS) $display("unexpected result word at %0t", $realtime);
      end else begin
        want_word = bus_levels_q.pop_front();
        if (got_word.scl_out !== want_word.scl_out
            || got_word.sda_drive_low !== want_word.sda_drive_low
            || got_word.busy_res !== want_word.busy_res
            || got_word.done_res !== want_word.done_res
            || got_word.read_data !== want_word.read_data
            || got_word.ack_error !== want_word.ack_error) begin
          errors = errors + 1;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch at %0t: exp scl %b sda_low %b busy %b done %b rd %h err %b",
                     $realtime, want_word.scl_out, want_word.sda_drive_low,
                     want_word.busy_res, want_word.done_res, want_word.read_data,
                     want_word.ack_error);
            $display("               got scl %b sda_low %b busy %b done %b rd %h err %b",
                     got_word.scl_out, got_word.sda_drive_low, got_word.busy_res,
                     got_word.done_res, got_word.read_data, got_word.ack_error);
          end
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule
